// ===== rtl/obfl_pkg.sv =====
`default_nettype none
package obfl_pkg;

   // Table sizes: powers of two, so ids and ticks reduce by truncation.
   localparam int ORDER_SLOTS  = 1024;
   localparam int PRICE_LEVELS = 1024;
   localparam int QTY_BITS     = 32;

   localparam int OID_W       = $clog2(ORDER_SLOTS);
   localparam int PRICE_W     = $clog2(PRICE_LEVELS);
   localparam int LEVEL_COUNT = 2 * PRICE_LEVELS;
   localparam int LV_W        = $clog2(LEVEL_COUNT);
   localparam int LINK_W      = OID_W + 1;
   localparam int CNT_W       = 11;
   localparam int SUM_W       = 42;

   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(ORDER_SLOTS);

   localparam logic [1:0] MODE_ADD    = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_CHANGE = 2'd2;

   localparam logic [2:0] STATUS_ADDED     = 3'd0;
   localparam logic [2:0] STATUS_PRESENT   = 3'd1;
   localparam logic [2:0] STATUS_REMOVED   = 3'd2;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd3;
   localparam logic [2:0] STATUS_CHANGED   = 3'd4;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_ORD,
      ST_CHK,
      ST_UNLINK,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_ADD_LINK,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic       load_req;
      logic       clr_wr;
      logic       unlink_wr;
      logic       add_wr;
      logic       link_wr;
      logic       rd_new_level;
      logic       set_pend;
      logic       pend_zero;
      logic [2:0] pend_status;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       present;
      logic       tail_valid;
      logic       rsp_free;
      logic       clr_last;
   } sts_type;

endpackage
`default_nettype wire

// ===== rtl/obfl_ctrl.sv =====
`default_nettype none
module obfl_ctrl
   import obfl_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_RD_ORD;
         end
         ST_RD_ORD: state_in = ST_CHK;
         ST_CHK: begin
            if (sts.mode == MODE_ADD) begin
               state_in = sts.present ? ST_RESP : ST_ADD_RD;
            end else if ((sts.mode == MODE_REMOVE || sts.mode == MODE_CHANGE)
                         && sts.present) begin
               state_in = ST_UNLINK;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_UNLINK: begin
            state_in = (sts.mode == MODE_REMOVE) ? ST_RESP : ST_ADD_RD;
         end
         ST_ADD_RD: state_in = ST_ADD_WR;
         ST_ADD_WR: begin
            state_in = sts.tail_valid ? ST_ADD_LINK : ST_RESP;
         end
         ST_ADD_LINK: state_in = ST_RESP;
         ST_RESP: begin
            if (sts.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_CLEAR: cmd.clr_wr = 1'b1;
         ST_IDLE:  cmd.load_req = req_valid;
         ST_CHK: begin
            if (sts.mode == MODE_ADD) begin
               if (sts.present) begin
                  cmd.set_pend    = 1'b1;
                  cmd.pend_zero   = 1'b1;
                  cmd.pend_status = STATUS_PRESENT;
               end
            end else if (!((sts.mode == MODE_REMOVE || sts.mode == MODE_CHANGE)
                           && sts.present)) begin
               cmd.set_pend    = 1'b1;
               cmd.pend_zero   = 1'b1;
               cmd.pend_status = STATUS_NOT_FOUND;
            end
         end
         ST_UNLINK: begin
            cmd.unlink_wr = 1'b1;
            if (sts.mode == MODE_REMOVE) begin
               cmd.set_pend    = 1'b1;
               cmd.pend_status = STATUS_REMOVED;
            end
         end
         ST_ADD_RD: cmd.rd_new_level = 1'b1;
         ST_ADD_WR: begin
            cmd.add_wr      = 1'b1;
            cmd.set_pend    = 1'b1;
            cmd.pend_status = (sts.mode == MODE_ADD) ? STATUS_ADDED : STATUS_CHANGED;
         end
         ST_ADD_LINK: cmd.link_wr = 1'b1;
         ST_RESP: cmd.load_rsp = sts.rsp_free;
         default: cmd = '0;
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/obfl_dp.sv =====
`default_nettype none
module obfl_dp
   import obfl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output sts_type          sts,
   input  wire logic [1:0]  req_mode,
   input  wire logic [9:0]  req_order_id,
   input  wire logic        req_is_buy,
   input  wire logic [9:0]  req_price_tick,
   input  wire logic [31:0] req_quantity,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic             rsp_level_side,
   output logic [9:0]       rsp_level_price,
   output logic [10:0]      rsp_level_orders,
   output logic [41:0]      rsp_level_total_qty
);

   localparam int INFO_W = 2 + PRICE_W + QTY_BITS;
   localparam int LVL_W  = 2 * LINK_W + CNT_W + SUM_W;

   // memories
   logic [INFO_W-1:0] info_mem  [ORDER_SLOTS];
   logic [LINK_W-1:0] prev_mem  [ORDER_SLOTS];
   logic [LINK_W-1:0] next_mem  [ORDER_SLOTS];
   logic [LVL_W-1:0]  level_mem [LEVEL_COUNT];

   logic [INFO_W-1:0] info_rd_ff;
   logic [LINK_W-1:0] prev_rd_ff;
   logic [LINK_W-1:0] next_rd_ff;
   logic [LVL_W-1:0]  level_rd_ff;

   // request
   logic [1:0]          mode_ff;
   logic [OID_W-1:0]    id_ff;
   logic                side_ff;
   logic [PRICE_W-1:0]  price_ff;
   logic [QTY_BITS-1:0] qty_ff;

   logic [LV_W-1:0]   clr_cnt_ff;
   logic [LINK_W-1:0] tail_keep_ff;

   // pending result
   logic [2:0]       pend_status_ff;
   logic             pend_side_ff;
   logic [9:0]       pend_price_ff;
   logic [CNT_W-1:0] pend_cnt_ff;
   logic [SUM_W-1:0] pend_sum_ff;

   logic rsp_valid_ff;
   logic rsp_valid_in;

   // decoded reads
   logic                o_present;
   logic                o_side;
   logic [PRICE_W-1:0]  o_price;
   logic [QTY_BITS-1:0] o_qty;
   logic [LINK_W-1:0]   l_head;
   logic [LINK_W-1:0]   l_tail;
   logic [CNT_W-1:0]    l_cnt;
   logic [SUM_W-1:0]    l_sum;

   assign {o_present, o_side, o_price, o_qty} = info_rd_ff;
   assign {l_head, l_tail, l_cnt, l_sum}     = level_rd_ff;

   logic [LV_W-1:0]   old_level;
   logic [LV_W-1:0]   new_level;
   logic [LV_W-1:0]   level_ra;
   logic [LINK_W-1:0] id_link;
   logic              p_valid;
   logic              n_valid;
   logic              t_valid;

   assign old_level = {o_side, o_price};
   assign new_level = {side_ff, price_ff};
   assign level_ra  = cmd.rd_new_level ? new_level : old_level;
   assign id_link   = {1'b0, id_ff};
   assign p_valid   = (prev_rd_ff < NULL_LINK);
   assign n_valid   = (next_rd_ff < NULL_LINK);
   assign t_valid   = (l_tail < NULL_LINK);

   // level updates
   logic [LINK_W-1:0] un_head, un_tail, ad_head;
   logic [CNT_W-1:0]  un_cnt, ad_cnt;
   logic [SUM_W-1:0]  un_sum, ad_sum;

   always_comb begin
      un_head = p_valid ? l_head : next_rd_ff;
      un_tail = n_valid ? l_tail : prev_rd_ff;
      un_cnt  = l_cnt - CNT_W'(1);
      un_sum  = l_sum - SUM_W'(o_qty);
      ad_head = t_valid ? l_head : id_link;
      ad_cnt  = l_cnt + CNT_W'(1);
      ad_sum  = l_sum + SUM_W'(qty_ff);
   end

   // write port selection
   logic              info_we, prev_we, next_we, level_we;
   logic [OID_W-1:0]  info_wa, prev_wa, next_wa;
   logic [LV_W-1:0]   level_wa;
   logic [INFO_W-1:0] info_wd;
   logic [LINK_W-1:0] prev_wd, next_wd;
   logic [LVL_W-1:0]  level_wd;

   always_comb begin
      info_we  = 1'b0;
      prev_we  = 1'b0;
      next_we  = 1'b0;
      level_we = 1'b0;
      info_wa  = id_ff;
      prev_wa  = id_ff;
      next_wa  = id_ff;
      level_wa = old_level;
      info_wd  = '0;
      prev_wd  = NULL_LINK;
      next_wd  = NULL_LINK;
      level_wd = {NULL_LINK, NULL_LINK, CNT_W'(0), SUM_W'(0)};
      if (cmd.clr_wr) begin
         info_we  = 1'b1;
         info_wa  = clr_cnt_ff[OID_W-1:0];
         level_we = 1'b1;
         level_wa = clr_cnt_ff;
      end
      if (cmd.unlink_wr) begin
         info_we  = 1'b1;
         info_wd  = {1'b0, o_side, o_price, o_qty};
         level_we = 1'b1;
         level_wa = old_level;
         level_wd = {un_head, un_tail, un_cnt, un_sum};
         next_we  = p_valid;
         next_wa  = prev_rd_ff[OID_W-1:0];
         next_wd  = next_rd_ff;
         prev_we  = n_valid;
         prev_wa  = next_rd_ff[OID_W-1:0];
         prev_wd  = prev_rd_ff;
      end
      if (cmd.add_wr) begin
         info_we  = 1'b1;
         info_wd  = {1'b1, side_ff, price_ff, qty_ff};
         level_we = 1'b1;
         level_wa = new_level;
         level_wd = {ad_head, id_link, ad_cnt, ad_sum};
         prev_we  = 1'b1;
         prev_wd  = t_valid ? l_tail : NULL_LINK;
         next_we  = 1'b1;
         next_wd  = NULL_LINK;
      end
      if (cmd.link_wr) begin
         next_we = 1'b1;
         next_wa = tail_keep_ff[OID_W-1:0];
         next_wd = id_link;
      end
   end

   always_ff @(posedge clock) begin
      if (info_we) info_mem[info_wa] <= info_wd;
      info_rd_ff <= info_mem[id_ff];
   end

   always_ff @(posedge clock) begin
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      prev_rd_ff <= prev_mem[id_ff];
   end

   always_ff @(posedge clock) begin
      if (next_we) next_mem[next_wa] <= next_wd;
      next_rd_ff <= next_mem[id_ff];
   end

   always_ff @(posedge clock) begin
      if (level_we) level_mem[level_wa] <= level_wd;
      level_rd_ff <= level_mem[level_ra];
   end

   // request, tail and pending registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff  <= req_mode;
         id_ff    <= req_order_id[OID_W-1:0];
         side_ff  <= req_is_buy;
         price_ff <= req_price_tick[PRICE_W-1:0];
         qty_ff   <= req_quantity[QTY_BITS-1:0];
      end
      if (cmd.add_wr) tail_keep_ff <= l_tail;
      if (cmd.set_pend) begin
         pend_status_ff <= cmd.pend_status;
         if (cmd.pend_zero) begin
            pend_side_ff  <= 1'b0;
            pend_price_ff <= '0;
            pend_cnt_ff   <= '0;
            pend_sum_ff   <= '0;
         end else if (cmd.unlink_wr) begin
            pend_side_ff  <= o_side;
            pend_price_ff <= 10'(o_price);
            pend_cnt_ff   <= un_cnt;
            pend_sum_ff   <= un_sum;
         end else begin
            pend_side_ff  <= side_ff;
            pend_price_ff <= 10'(price_ff);
            pend_cnt_ff   <= ad_cnt;
            pend_sum_ff   <= ad_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_cnt_ff <= clr_cnt_ff + LV_W'(1);
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status          <= pend_status_ff;
         rsp_level_side      <= pend_side_ff;
         rsp_level_price     <= pend_price_ff;
         rsp_level_orders    <= pend_cnt_ff;
         rsp_level_total_qty <= pend_sum_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      sts.mode       = mode_ff;
      sts.present    = o_present;
      sts.tail_valid = t_valid;
      sts.rsp_free   = !rsp_valid_ff || !rsp_stall;
      sts.clr_last   = (clr_cnt_ff == LV_W'(LEVEL_COUNT - 1));
   end

endmodule
`default_nettype wire

// ===== rtl/order_book_fifo_levels.sv =====
`default_nettype none
// Channel  Ports                                               Direction
// req      req_valid req_stall mode order_id is_buy price tick qty in
// rsp      rsp_valid rsp_stall status level side/price/orders/qty out
//
// One transaction at a time: read and check the order, unlink it for a
// remove or change, read and write the new level for an add or change,
// link a non-empty tail, then wait out any rsp stall. The steps follow
// the single read port of each table memory. After reset the level and
// order tables are swept clean while req_stall stays high.
// A finished transaction sits in the rsp output register; the next request
// is taken meanwhile and only its reply waits on rsp_stall.
module order_book_fifo_levels
   import obfl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_mode,
   input  wire logic [9:0]  req_order_id,
   input  wire logic        req_is_buy,
   input  wire logic [9:0]  req_price_tick,
   input  wire logic [31:0] req_quantity,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic             rsp_level_side,
   output logic [9:0]       rsp_level_price,
   output logic [10:0]      rsp_level_orders,
   output logic [41:0]      rsp_level_total_qty
);

   cmd_type cmd;
   sts_type sts;

   // sequence the table accesses of each transaction
   obfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // hold the order and level tables, link updates and the rsp register
   obfl_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_mode            (req_mode),
      .req_order_id        (req_order_id),
      .req_is_buy          (req_is_buy),
      .req_price_tick      (req_price_tick),
      .req_quantity        (req_quantity),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_level_side      (rsp_level_side),
      .rsp_level_price     (rsp_level_price),
      .rsp_level_orders    (rsp_level_orders),
      .rsp_level_total_qty (rsp_level_total_qty)
   );

endmodule
`default_nettype wire

// ===== dv/tb_order_book_fifo_levels.sv =====
`default_nettype none
module tb_order_book_fifo_levels;
   import obfl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // mode code that the block leaves unused
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // One expected reply of the book.
   typedef struct {
      logic [2:0]  status;
      logic        side;
      logic [9:0]  price;
      logic [10:0] orders;
      logic [41:0] total_qty;
   } book_reply_type;

   // Book shadow and reply queue: notes each accepted request, checks each reply.
   class book_scoreboard;
      bit          resting [ORDER_SLOTS];
      bit          rest_side [ORDER_SLOTS];
      logic [9:0]  rest_price [ORDER_SLOTS];
      logic [31:0] rest_qty [ORDER_SLOTS];
      // FIFO order per level, kept as a queue of ids
      int          level_queue [LEVEL_COUNT][$];
      logic [41:0] level_sum [LEVEL_COUNT];
      book_reply_type replies_due [$];
      int          mismatches;
      int          checked;
      int          n_added, n_dup, n_removed, n_missing, n_changed;

      function new();
         foreach (level_sum[i]) level_sum[i] = '0;
         mismatches = 0;
         checked = 0;
      endfunction

      function void drop_order(int id);
         int lv;
         lv = rest_side[id] * PRICE_LEVELS + rest_price[id];
         foreach (level_queue[lv][k])
            if (level_queue[lv][k] == id) begin
               level_queue[lv].delete(k);
               break;
            end
         level_sum[lv] = level_sum[lv] - rest_qty[id];
         resting[id] = 0;
      endfunction

      function void rest_order(int id, bit side, logic [9:0] price, logic [31:0] qty);
         int lv;
         lv = side * PRICE_LEVELS + price;
         resting[id] = 1;
         rest_side[id] = side;
         rest_price[id] = price;
         rest_qty[id] = qty;
         level_queue[lv].push_back(id);
         level_sum[lv] = level_sum[lv] + qty;
      endfunction

      function book_reply_type level_reply(logic [2:0] st, bit side, logic [9:0] price);
         book_reply_type r;
         int lv;
         lv = side * PRICE_LEVELS + price;
         r.status = st;
         r.side = side;
         r.price = price;
         r.orders = level_queue[lv].size();
         r.total_qty = level_sum[lv];
         return r;
      endfunction

      function void note_request(logic [1:0] mode, logic [9:0] id, bit side,
                                 logic [9:0] price, logic [31:0] qty);
         book_reply_type r;
         bit          s;
         logic [9:0]  p;
         r = '{STATUS_NOT_FOUND, 1'b0, 10'd0, 11'd0, 42'd0};
         if (mode == MODE_ADD) begin
            if (resting[id]) begin
               r.status = STATUS_PRESENT;
               n_dup++;
            end else begin
               rest_order(id, side, price, qty);
               r = level_reply(STATUS_ADDED, side, price);
               n_added++;
            end
         end else if (mode == MODE_REMOVE && resting[id]) begin
            s = rest_side[id];
            p = rest_price[id];
            drop_order(id);
            r = level_reply(STATUS_REMOVED, s, p);
            n_removed++;
         end else if (mode == MODE_CHANGE && resting[id]) begin
            drop_order(id);
            rest_order(id, side, price, qty);
            r = level_reply(STATUS_CHANGED, side, price);
            n_changed++;
         end else begin
            n_missing++;
         end
         replies_due.push_back(r);
      endfunction

      function void check_reply(book_reply_type got);
         book_reply_type want;
         if (replies_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR %0t: reply with none outstanding, status %0d", $time,
                        got.status);
            return;
         end
         want = replies_due.pop_front();
         checked++;
         if (got.status !== want.status || got.side !== want.side ||
             got.price !== want.price || got.orders !== want.orders ||
             got.total_qty !== want.total_qty) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR %0t: reply %0d exp st=%0d side=%0d px=%0d n=%0d qty=%0d,",
                        $time, checked, want.status, want.side, want.price, want.orders,
                        want.total_qty,
                        " got st=%0d side=%0d px=%0d n=%0d qty=%0d",
                        got.status, got.side, got.price, got.orders, got.total_qty);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode = '0;
   logic [9:0]  req_order_id = '0;
   logic        req_is_buy = 1'b0;
   logic [9:0]  req_price_tick = '0;
   logic [31:0] req_quantity = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic [2:0]  rsp_status;
   logic        rsp_level_side;
   logic [9:0]  rsp_level_price;
   logic [10:0] rsp_level_orders;
   logic [41:0] rsp_level_total_qty;

   book_scoreboard book;
   // Hold off the reply side while set; the reply process obeys it.
   bit          hold_replies = 1'b0;
   bit          quiet_replies = 1'b0;

   always #1 clock = ~clock;

   order_book_fifo_levels u_dut (
      .clock, .reset, .req_valid, .req_stall, .req_mode, .req_order_id, .req_is_buy,
      .req_price_tick, .req_quantity, .rsp_valid, .rsp_stall, .rsp_status,
      .rsp_level_side, .rsp_level_price, .rsp_level_orders, .rsp_level_total_qty
   );

   // Offer one transaction after a random gap unless no_gap is set; note it when the block takes it.
   task automatic send_order(logic [1:0] mode, logic [9:0] id, bit side,
                             logic [9:0] price, logic [31:0] qty, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 8);
      // drop valid only across a gap; back to back it stays high
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_order_id <= id;
      req_is_buy <= side;
      req_price_tick <= price;
      req_quantity <= qty;
      do @(posedge clock); while (req_stall);
      book.note_request(mode, id, side, price, qty);
   endtask

   task automatic idle_sender();
      req_valid <= 1'b0;
   endtask

   // Wait until every outstanding reply has come back.
   task automatic drain_book();
      while (book.replies_due.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_qty();
      case ($urandom_range(0, 3))
         0: return 32'hFFFF_FFFF;
         1: return $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   // Reply side: random stall per reply, long hold when asked; check each transaction.
   initial begin : reply_side
      int wait_cycles;
      @(negedge reset);
      forever begin
         if (hold_replies) begin
            rsp_stall <= 1'b1;
            @(posedge clock);
         end else begin
            wait_cycles = quiet_replies ? 0 : $urandom_range(0, 8);
            if (wait_cycles != 0) begin
               rsp_stall <= 1'b1;
               repeat (wait_cycles) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            @(posedge clock);
            if (rsp_valid && !rsp_stall)
               book.check_reply('{rsp_status, rsp_level_side, rsp_level_price,
                                  rsp_level_orders, rsp_level_total_qty});
         end
      end
   end

   initial begin : watchdog
      #4ms;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      int          id, pick, hot_id;
      logic [9:0]  hot_px;
      int          live_ids [$];
      book = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: build a short queue at one level, then unlink middle, head, tail, only.
      send_order(MODE_ADD, 10'd1, 1'b1, 10'd1023, 32'hFFFF_FFFF);
      send_order(MODE_ADD, 10'd2, 1'b1, 10'd1023, 32'd5);
      send_order(MODE_ADD, 10'd3, 1'b1, 10'd1023, 32'd7);
      send_order(MODE_ADD, 10'd1023, 1'b1, 10'd1023, 32'hFFFF_FFFF);
      send_order(MODE_ADD, 10'd2, 1'b0, 10'd0, 32'd9);          // duplicate id
      send_order(MODE_REMOVE, 10'd2, 1'b0, 10'd0, 32'd0);       // middle
      send_order(MODE_REMOVE, 10'd1, 1'b0, 10'd0, 32'd0);       // head
      send_order(MODE_REMOVE, 10'd1023, 1'b0, 10'd0, 32'd0);    // tail
      send_order(MODE_REMOVE, 10'd3, 1'b0, 10'd0, 32'd0);       // only element
      send_order(MODE_REMOVE, 10'd3, 1'b0, 10'd0, 32'd0);       // absent
      send_order(MODE_CHANGE, 10'd500, 1'b0, 10'd4, 32'd1);     // change of absent id
      send_order(MODE_UNUSED, 10'd500, 1'b1, 10'd4, 32'd1);     // unused mode
      send_order(MODE_ADD, 10'd0, 1'b0, 10'd0, 32'd0);
      send_order(MODE_ADD, 10'd4, 1'b0, 10'd0, 32'd3);
      send_order(MODE_CHANGE, 10'd0, 1'b1, 10'd512, 32'hFFFF_FFFF); // loses its place
      send_order(MODE_CHANGE, 10'd4, 1'b1, 10'd512, 32'd8);
      send_order(MODE_CHANGE, 10'd0, 1'b1, 10'd512, 32'd2);     // same level, to the back
      send_order(MODE_REMOVE, 10'd4, 1'b0, 10'd0, 32'd0);
      send_order(MODE_REMOVE, 10'd0, 1'b0, 10'd0, 32'd0);
      idle_sender();

      // Sender pause: wait for every reply before the long receiver hold.
      drain_book();

      // Long receiver hold while requests keep coming; the block must back up.
      hold_replies = 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_replies = 1'b0;
         end
         for (int k = 0; k < 12; k++)
            send_order(MODE_ADD, 10'(600 + k), k[0], 10'(k % 3), $urandom, 1'b1);
      join
      idle_sender();

      // Random part: mostly hits on live ids over a few crowded levels.
      for (int n = 0; n < 1100; n++) begin
         // a stretch with no stalls or gaps on either side
         quiet_replies = (n >= 500 && n < 600);
         hot_px = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 3));
         pick = $urandom_range(0, 9);
         if (live_ids.size() == 0 || pick < 4) begin
            id = (pick == 0 && live_ids.size() != 0) ? live_ids[$urandom_range(0,
                  live_ids.size() - 1)] : $urandom_range(0, 1023);
            send_order(MODE_ADD, 10'(id), 1'($urandom), hot_px, rand_qty(), quiet_replies);
         end else begin
            hot_id = (pick == 9) ? $urandom_range(0, 1023)
                                 : live_ids[$urandom_range(0, live_ids.size() - 1)];
            send_order(($urandom_range(0, 19) == 0) ? MODE_UNUSED :
                       ((pick < 7) ? MODE_REMOVE : MODE_CHANGE),
                       10'(hot_id), 1'($urandom), hot_px, rand_qty(), quiet_replies);
         end
         live_ids = {};
         foreach (book.resting[i]) if (book.resting[i]) live_ids.push_back(i);
      end
      idle_sender();

      drain_book();
      repeat (40) @(posedge clock);
      $display("Covered %0d replies: %0d adds, %0d duplicates, %0d removes, %0d changes,",
               book.checked, book.n_added, book.n_dup, book.n_removed, book.n_changed);
      $display("%0d misses or unused modes; %0d mismatches.", book.n_missing,
               book.mismatches);
      if (book.mismatches == 0 && book.replies_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
